// ----- design/msb_first_bit_packer_top_defines.svh -----
// Assertion macros for the MSB-first bit packer.
// Included by the RTL file that carries concurrent checks (mfbp_dp); no other dependencies.
`ifndef MSB_FIRST_BIT_PACKER_TOP_DEFINES_SVH
`define MSB_FIRST_BIT_PACKER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// check while out of reset
`define MFBP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check on every edge, reset included
`define MFBP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MFBP_ASSERT(lbl, clk, rst_n, prop, msg)
`define MFBP_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ----- design/mfbp_pkg.sv -----
// Package for the MSB-first bit packer: sizes, opcodes, controller/datapath structs.
// No dependencies.
package mfbp_pkg;

    localparam int VALUE_BITS = 64;
    localparam int BCNT_W     = 7;                        // bit_count field width
    localparam int SREG_W     = VALUE_BITS + 8;           // held byte plus value bits
    localparam int SUM_W      = $clog2(SREG_W);           // total bit count width
    localparam int MAX_BYTES  = (VALUE_BITS + 7) / 8;
    localparam int NB_W       = $clog2(MAX_BYTES + 1);

    localparam logic OP_PUSH  = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    typedef struct packed {
        logic load;     // capture the input word and the byte count
        logic shift;    // current output byte taken, move to the next
    } t_dp_cmd;

    typedef struct packed {
        logic load_empty;   // the input word at the port yields no byte
        logic last_byte;    // the byte on the output is the final one of its word
    } t_dp_sts;

endpackage

// ----- design/mfbp_ctrl.sv -----
// Controller for the MSB-first bit packer: accepts a word, then steps the
// datapath through its output bytes. Depends on mfbp_pkg.
module mfbp_ctrl
    import mfbp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_dp_cmd o_cmd,
    input  t_dp_sts i_sts
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EMIT = 1'b1;

    logic r_state;
    logic n_state;

    always_comb begin
        n_state     = r_state;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (!i_sts.load_empty) begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_EMIT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    o_cmd.shift = 1'b1;
                    if (i_sts.last_byte) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- design/mfbp_dp.sv -----
// Datapath for the MSB-first bit packer: bit-stream shift register, held-bit
// count and output byte counter. Depends on mfbp_pkg and the defines header.
`include "msb_first_bit_packer_top_defines.svh"

module mfbp_dp
    import mfbp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_sts               o_sts,
    input  logic                  i_opcode,
    input  logic [VALUE_BITS-1:0] i_field_value,
    input  logic [BCNT_W-1:0]     i_bit_count,
    output logic [7:0]            o_out_byte,
    output logic                  o_last
);

    // top byte holds the pending bits left-aligned; everything below is zero when idle
    logic [SREG_W-1:0] r_sreg;
    logic [SREG_W-1:0] n_sreg;
    logic [2:0]        r_filled;
    logic [2:0]        n_filled;
    logic [NB_W-1:0]   r_left;
    logic [NB_W-1:0]   n_left;

    logic [BCNT_W-1:0]     c_count;
    logic [VALUE_BITS-1:0] c_val_al;
    logic [SREG_W-1:0]     c_stream;
    logic [SUM_W-1:0]      c_total;
    logic [NB_W-1:0]       c_nbytes;
    logic [SREG_W-1:0]     c_word;

    always_comb begin
        if (i_bit_count > BCNT_W'(VALUE_BITS)) begin
            c_count = BCNT_W'(VALUE_BITS);
        end else begin
            c_count = i_bit_count;
        end
        // left-align the used bits; the shift drops bits above the count
        c_val_al = i_field_value << (BCNT_W'(VALUE_BITS) - c_count);
        c_stream = {c_val_al, 8'h00} >> r_filled;
        c_total  = SUM_W'(r_filled) + SUM_W'(c_count);
        if (i_opcode == OP_FLUSH) begin
            c_word   = r_sreg;
            c_nbytes = NB_W'(r_filled != 3'd0);
        end else begin
            c_word   = r_sreg | c_stream;
            c_nbytes = NB_W'(c_total >> 3);
        end
    end

    assign o_sts.load_empty = (c_nbytes == '0);
    assign o_sts.last_byte  = (r_left == NB_W'(1));
    assign o_out_byte       = r_sreg[SREG_W-1 -: 8];
    assign o_last           = (r_left == NB_W'(1));

    always_comb begin
        n_sreg   = r_sreg;
        n_filled = r_filled;
        n_left   = r_left;
        if (i_cmd.load) begin
            n_sreg   = c_word;
            n_left   = c_nbytes;
            n_filled = (i_opcode == OP_FLUSH) ? 3'd0 : c_total[2:0];
        end else if (i_cmd.shift) begin
            n_sreg = r_sreg << 8;
            n_left = r_left - NB_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sreg   <= '0;
            r_filled <= '0;
            r_left   <= '0;
        end else begin
            r_sreg   <= n_sreg;
            r_filled <= n_filled;
            r_left   <= n_left;
        end
    end

    `MFBP_ASSERT(a_idle_low_zero, i_clk, i_rst_n, (r_left == '0) |-> (r_sreg[SREG_W-9:0] == '0), "stream bits left below held byte")
    `MFBP_ASSERT(a_empty_held_zero, i_clk, i_rst_n, ((r_left == '0) && (r_filled == 3'd0)) |-> (r_sreg[SREG_W-1 -: 8] == 8'h00), "held byte nonzero with no bits")
    `MFBP_ASSERT(a_shift_has_byte, i_clk, i_rst_n, i_cmd.shift |-> (r_left != '0), "shift with no byte pending")
    `MFBP_ASSERT(a_left_range, i_clk, i_rst_n, (r_left <= NB_W'(MAX_BYTES)), "byte count out of range")
    `MFBP_ASSERT_ALWAYS(a_cmd_excl, i_clk, !(i_cmd.load && i_cmd.shift), "load and shift together")

endmodule

// ----- design/msb_first_bit_packer_top.sv -----
// MSB-first bit packer: a word is accepted while idle, and its n output bytes (0..8)
// follow one per cycle, held while out_ready is low, starting the next cycle; ready
// returns the cycle after the last byte is taken, so no new word is taken while bytes
// are pending. Synchronous active-low reset clears the held bits and the byte
// counter. Depends on mfbp_pkg, mfbp_ctrl and mfbp_dp.
module msb_first_bit_packer_top
    import mfbp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_opcode,
    input  logic [VALUE_BITS-1:0] i_field_value,
    input  logic [BCNT_W-1:0]     i_bit_count,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [7:0]            o_out_byte,
    output logic                  o_last
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    mfbp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    mfbp_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_opcode      (i_opcode),
        .i_field_value (i_field_value),
        .i_bit_count   (i_bit_count),
        .o_out_byte    (o_out_byte),
        .o_last        (o_last)
    );

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// Testbench for msb_first_bit_packer_top: random-idle valid/ready traffic with a bit-level
// packing predictor and an in-order byte checker. Depends on mfbp_pkg and the packer RTL.
module tb;
    import mfbp_pkg::*;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } t_packed_byte;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic                  opcode = OP_PUSH;
    logic [VALUE_BITS-1:0] field_value = '0;
    logic [BCNT_W-1:0]     bit_count = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [7:0]            out_byte;
    logic                  out_last;

    t_packed_byte byte_q[$];
    logic [7:0]   held_byte = '0;
    int           held_bits = 0;

    int  errors = 0;
    int  words_sent = 0;
    int  flushes_sent = 0;
    int  bytes_checked = 0;
    bit  tx_no_gaps = 1'b0;
    bit  rx_no_gaps = 1'b0;
    int  rx_hold_cycles = 0;

    msb_first_bit_packer_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_opcode      (opcode),
        .i_field_value (field_value),
        .i_bit_count   (bit_count),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_out_byte    (out_byte),
        .o_last        (out_last)
    );

    always #5 i_clk = ~i_clk;

    // Append the word bit by bit, MSB first, queueing full bytes; a flush queues held bits.
    function automatic void pack_word(logic op, logic [VALUE_BITS-1:0] val,
                                      logic [BCNT_W-1:0] cnt);
        t_packed_byte produced[$];
        t_packed_byte rec;
        int           nbits;
        if (op == OP_FLUSH) begin
            if (held_bits != 0) begin
                rec.data = held_byte;
                rec.last = 1'b0;
                produced.push_back(rec);
                held_byte = '0;
                held_bits = 0;
            end
        end else begin
            nbits = (cnt > VALUE_BITS) ? VALUE_BITS : int'(cnt);
            for (int i = nbits - 1; i >= 0; i--) begin
                held_byte[7 - held_bits] = val[i];
                held_bits++;
                if (held_bits == 8) begin
                    rec.data = held_byte;
                    rec.last = 1'b0;
                    produced.push_back(rec);
                    held_byte = '0;
                    held_bits = 0;
                end
            end
        end
        if (produced.size() > 0)
            produced[produced.size() - 1].last = 1'b1;
        foreach (produced[k])
            byte_q.push_back(produced[k]);
    endfunction

    function automatic logic [VALUE_BITS-1:0] rand_value();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [BCNT_W-1:0] rand_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return '0;
        else if (r < 20)
            return BCNT_W'(VALUE_BITS);
        else if (r < 28)
            return BCNT_W'($urandom_range(VALUE_BITS + 1, 127));
        else
            return BCNT_W'($urandom_range(1, VALUE_BITS - 1));
    endfunction

    // Called at a rising edge; returns at the edge where the word is taken.
    task automatic send_word(logic op, logic [VALUE_BITS-1:0] val, logic [BCNT_W-1:0] cnt);
        int gap;
        gap = tx_no_gaps ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid    <= 1'b1;
        opcode      <= op;
        field_value <= val;
        bit_count   <= cnt;
        do @(negedge i_clk); while (!in_ready);
        @(posedge i_clk);
        pack_word(op, val, cnt);
        words_sent++;
        if (op == OP_FLUSH)
            flushes_sent++;
    endtask

    task automatic send_random();
        if ($urandom_range(0, 99) < 12)
            send_word(OP_FLUSH, rand_value(), BCNT_W'($urandom));
        else
            send_word(OP_PUSH, rand_value(), rand_count());
    endtask

    // Sender goes quiet until every expected byte is out.
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge i_clk); while (byte_q.size() != 0);
    endtask

    task automatic test_directed();
        send_word(OP_PUSH,  rand_value(), 7'd0);               // zero count, nothing held
        send_word(OP_FLUSH, '1, 7'd64);                        // flush with nothing held
        send_word(OP_PUSH,  64'hA5, 7'd8);
        send_word(OP_PUSH,  64'h0123_4567_89AB_CDEF, 7'd64);
        send_word(OP_PUSH,  64'hFFFF_FFFF_FFFF_FFFD, 7'd3);    // junk above the count
        send_word(OP_PUSH,  rand_value(), 7'd0);               // zero count with held bits
        send_word(OP_FLUSH, rand_value(), 7'd127);             // flush operands ignored
        send_word(OP_PUSH,  64'h1, 7'd1);
        send_word(OP_PUSH,  '1, 7'd64);                        // top-up plus seven whole bytes
        send_word(OP_PUSH,  64'h0, 7'd7);
        send_word(OP_PUSH,  64'h55, 7'd7);
        send_word(OP_PUSH,  rand_value(), 7'd57);              // lands exactly on eight bytes
        send_word(OP_PUSH,  rand_value(), 7'd127);             // oversized count clamps
        send_word(OP_PUSH,  rand_value(), 7'd65);
        send_word(OP_PUSH,  64'h0, 7'd100);
        send_word(OP_PUSH,  64'h1F, 7'd5);
        send_word(OP_FLUSH, 64'h0, 7'd0);
        send_word(OP_FLUSH, '1, 7'd0);
        send_word(OP_PUSH,  64'h0, 7'd64);
        send_word(OP_PUSH,  64'h8000_0000_0000_0000, 7'd64);
        send_word(OP_PUSH,  rand_value(), 7'd13);
        send_word(OP_PUSH,  rand_value(), 7'd2);
        send_word(OP_FLUSH, rand_value(), rand_count());
        drain();
    endtask

    task automatic test_random_traffic();
        repeat (150) send_random();
        drain();
    endtask

    task automatic test_back_to_back();
        tx_no_gaps = 1'b1;
        rx_no_gaps = 1'b1;
        repeat (30) send_random();
        drain();
        tx_no_gaps = 1'b0;
        rx_no_gaps = 1'b0;
    endtask

    // Consumer stalls for a long stretch while full-width words, then shorter ones, keep coming.
    task automatic test_output_stall();
        tx_no_gaps     = 1'b1;
        rx_hold_cycles = 300;
        repeat (8) send_word(OP_PUSH, rand_value(), 7'd64);
        repeat (7) send_word(OP_PUSH, rand_value(), BCNT_W'($urandom_range(1, 63)));
        tx_no_gaps = 1'b0;
        drain();
    endtask

    // Consumer: random stalls per byte, plus a requested long hold.
    initial begin
        int gap;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (rx_hold_cycles > 0) begin
                out_ready <= 1'b0;
                repeat (rx_hold_cycles) @(posedge i_clk);
                rx_hold_cycles = 0;
            end else begin
                gap = rx_no_gaps ? 0 : $urandom_range(0, 12);
                if (gap > 0) begin
                    out_ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            out_ready <= 1'b1;
            do @(negedge i_clk); while (!out_valid && rx_hold_cycles == 0);
            @(posedge i_clk);
        end
    end

    // Byte checker: sampled mid-cycle, so the handshake seen here completes at the next edge.
    always @(negedge i_clk) begin
        if (i_rst_n && out_valid && out_ready) begin
            if (byte_q.size() == 0) begin
                $display("%0t ERROR: unexpected byte: expected none, got byte %h last %b",
                         $time, out_byte, out_last);
                errors++;
            end else begin
                if (out_byte !== byte_q[0].data) begin
                    $display("%0t ERROR: out_byte expected %h, got %h",
                             $time, byte_q[0].data, out_byte);
                    errors++;
                end
                if (out_last !== byte_q[0].last) begin
                    $display("%0t ERROR: last expected %b, got %b",
                             $time, byte_q[0].last, out_last);
                    errors++;
                end
                void'(byte_q.pop_front());
                bytes_checked++;
            end
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_traffic();
        test_back_to_back();
        test_output_stall();
        in_valid <= 1'b0;
        repeat (20) @(posedge i_clk);
        $display("Sent %0d words (%0d flushes); checked %0d bytes, incl. back-to-back",
                 words_sent, flushes_sent, bytes_checked);
        $display("and a 300-cycle output stall; %0d mismatches.", errors);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("%0t timeout with %0d bytes outstanding", $time, byte_q.size());
        $display("CHECK FAILED");
        $finish;
    end

endmodule
